/* rtl/iphe_pkg.sv */
// ----------------------------------------------------------------------------
// Interferometer phase and elevation package
// Shared widths, register indexes, state type and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package iphe_pkg;

   // Default index limits.
   localparam int MaxRangesDefault = 256;
   localparam int MaxLagsDefault   = 32;

   // Field and datapath widths.
   localparam int CORR_W     = 32;   // correlation component
   localparam int ANGLE_W    = 32;   // binary angle, a full turn is 2^32
   localparam int DP_W       = 63;   // CORDIC x/y after scaling and growth
   localparam int PRESCALE   = 28;   // CORDIC input shift
   localparam int CORDIC_N   = 28;   // CORDIC iterations
   localparam int CNT_W      = 5;
   localparam int FREQ_W     = 16;
   localparam int BASE_W     = 10;
   localparam int DEN_W      = 28;   // 4 * frequency * baseline
   localparam int NUM_W      = 51;   // |diff| * 300000 + den / 2
   localparam int QUOT_W     = 31;   // asin argument magnitude, Q1.30
   localparam int ROOT_W     = 61;
   localparam int PROD_W     = 63;
   localparam int PHASE_W    = 16;
   localparam int ELEV_W     = 15;

   localparam logic [ANGLE_W-1:0] ANGLE_QUARTER       = 32'h4000_0000;
   localparam logic [ANGLE_W-1:0] ANGLE_THREE_QUARTER = 32'hC000_0000;

   localparam logic [30:0] PI_Q29       = 31'd1686629713;
   localparam logic [18:0] LAMBDA_SCALE = 19'd300000;
   localparam logic [5:0]  DEG_SCALE    = 6'd45;
   localparam logic [ELEV_W-1:0] ELEV_LIMIT = 15'd11520;

   // Configuration register indexes.
   localparam logic REG_FREQ = 1'b0;
   localparam logic REG_BASE = 1'b1;

   localparam logic [FREQ_W-1:0] FREQ_RESET = 16'd10000;
   localparam logic [BASE_W-1:0] BASE_RESET = 10'd100;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CORD_X,
      ST_CORD_A,
      ST_SCALE,
      ST_CHECK,
      ST_DIVIDE,
      ST_SQUARE,
      ST_ROOT,
      ST_CORD_E,
      ST_FINISH
   } state_type;

   // Arctangent of 2^-i as a binary angle.
   function automatic logic [ANGLE_W-1:0] atan_angle(input logic [CNT_W-1:0] i);
      logic [ANGLE_W-1:0] a;
      case (i)
         5'd0:  a = 32'd536870912;
         5'd1:  a = 32'd316933406;
         5'd2:  a = 32'd167458907;
         5'd3:  a = 32'd85004756;
         5'd4:  a = 32'd42667331;
         5'd5:  a = 32'd21354465;
         5'd6:  a = 32'd10679838;
         5'd7:  a = 32'd5340245;
         5'd8:  a = 32'd2670163;
         5'd9:  a = 32'd1335087;
         5'd10: a = 32'd667544;
         5'd11: a = 32'd333772;
         5'd12: a = 32'd166886;
         5'd13: a = 32'd83443;
         5'd14: a = 32'd41722;
         5'd15: a = 32'd20861;
         5'd16: a = 32'd10430;
         5'd17: a = 32'd5215;
         5'd18: a = 32'd2608;
         5'd19: a = 32'd1304;
         5'd20: a = 32'd652;
         5'd21: a = 32'd326;
         5'd22: a = 32'd163;
         5'd23: a = 32'd81;
         5'd24: a = 32'd41;
         5'd25: a = 32'd20;
         5'd26: a = 32'd10;
         5'd27: a = 32'd5;
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage

/* rtl/iphe_cordic.sv */
// ----------------------------------------------------------------------------
// CORDIC vectoring unit
// Finds the binary angle of a vector, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module iphe_cordic import iphe_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic signed [CORR_W-1:0]  x_in,
   input  logic signed [CORR_W-1:0]  y_in,
   output logic                      done,
   output logic [ANGLE_W-1:0]        angle
);

   logic signed [DP_W-1:0] x_ff, x_in_d, y_ff, y_in_d;
   logic [ANGLE_W-1:0]     a_ff, a_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   busy_ff, busy_in, done_ff, done_in;
   logic signed [DP_W-1:0] xs, ys, dx, dy;

   always_comb begin
      xs      = DP_W'(x_in) <<< PRESCALE;
      ys      = DP_W'(y_in) <<< PRESCALE;
      dx      = y_ff >>> cnt_ff;
      dy      = x_ff >>> cnt_ff;
      x_in_d  = x_ff;
      y_in_d  = y_ff;
      a_in    = a_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         cnt_in = '0;
         a_in   = '0;
         x_in_d = xs;
         y_in_d = ys;
         if (x_in == 0 && y_in == 0) begin
            // The angle of the origin is taken as zero.
            done_in = 1'b1;
            busy_in = 1'b0;
         end else begin
            busy_in = 1'b1;
            if (xs < 0) begin
               if (ys >= 0) begin
                  x_in_d = ys;
                  y_in_d = -xs;
                  a_in   = ANGLE_QUARTER;
               end else begin
                  x_in_d = -ys;
                  y_in_d = xs;
                  a_in   = ANGLE_THREE_QUARTER;
               end
            end
         end
      end else if (busy_ff) begin
         if (y_ff > 0) begin
            x_in_d = x_ff + dx;
            y_in_d = y_ff - dy;
            a_in   = a_ff + atan_angle(cnt_ff);
         end else begin
            x_in_d = x_ff - dx;
            y_in_d = y_ff + dy;
            a_in   = a_ff - atan_angle(cnt_ff);
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(CORDIC_N - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in_d;
      y_ff   <= y_in_d;
      a_ff   <= a_in;
      cnt_ff <= cnt_in;
   end

   assign done  = done_ff;
   assign angle = a_ff;

endmodule

/* rtl/interferometer_phase_elevation_core.sv */
// ----------------------------------------------------------------------------
// Interferometer phase difference and elevation angle
// Per lag: phase of the interferometer correlation minus that of the main
// correlation, in Q3.13 radians, and the arrival elevation in Q8.7 degrees.
// ----------------------------------------------------------------------------
// One lag is taken at a time. It occupies the block from its transfer on the
// req channel to the cycle in which its result is presented, and req_ready
// returns in that same cycle, so a new lag can be transferred while the
// result is presented. The time goes on three passes of a single 28-step
// CORDIC vectoring unit (interferometer phase, main phase, and the arcsine
// formed as atan2(s, sqrt(1 - s^2))), a 31-step restoring divider for the
// arcsine argument and a 31-step bit-pair square root. A correlation of zero
// magnitude finishes its CORDIC pass without any micro-rotation. When the
// phase difference is zero or the arcsine argument exceeds one, the divider,
// root and third CORDIC pass are skipped. req_ready is high only while the
// sequencer is idle; the result sits in its own output register, so the next
// lag can be transferred while the previous result still waits for
// rsp_ready. A phase difference of exactly pi is reported as -pi. An arcsine
// argument beyond one clips the elevation to plus or minus 90 degrees and
// sets rsp_elevation_clipped. Configuration writes are always accepted and
// must only be made while the block is idle.
// ----------------------------------------------------------------------------
module interferometer_phase_elevation_core import iphe_pkg::*; #(
   parameter int MAX_RANGES = MaxRangesDefault,
   parameter int MAX_LAGS   = MaxLagsDefault
) (
   input  logic                      clock,
   input  logic                      reset,
   // Configuration writes
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic                      csr_index,
   input  logic [FREQ_W-1:0]         csr_wdata,
   // Lag input
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [7:0]                req_range_index,
   input  logic [4:0]                req_lag_index,
   input  logic                      req_lag_valid,
   input  logic signed [CORR_W-1:0]  req_acf_real,
   input  logic signed [CORR_W-1:0]  req_acf_imag,
   input  logic signed [CORR_W-1:0]  req_xcf_real,
   input  logic signed [CORR_W-1:0]  req_xcf_imag,
   // Result
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [7:0]                rsp_range_index_out,
   output logic [4:0]                rsp_lag_index_out,
   output logic signed [PHASE_W-1:0] rsp_phase_difference,
   output logic signed [ELEV_W-1:0]  rsp_elevation_angle,
   output logic                      rsp_elevation_clipped
);

   // Sequencer and configuration.
   state_type            state_ff, state_in;
   logic [FREQ_W-1:0]    freq_ff;
   logic [BASE_W-1:0]    base_ff;

   // Item registers.
   logic [7:0]                 rng_ff, rng_in;
   logic [4:0]                 lag_ff, lag_in;
   logic                       phase_ok_ff, phase_ok_in;
   logic signed [CORR_W-1:0]   acf_re_ff, acf_re_in, acf_im_ff, acf_im_in;
   logic [ANGLE_W-1:0]         ang_x_ff, ang_x_in;
   logic [ANGLE_W-1:0]         diff_ff, diff_in;
   logic [PROD_W-1:0]          prod_ff, prod_in;
   logic [NUM_W-1:0]           num_ff, num_in;
   logic [DEN_W-1:0]           den_ff, den_in;
   logic [QUOT_W-1:0]          quot_ff, quot_in;
   logic [CNT_W-1:0]           k_ff, k_in;
   logic [ROOT_W-1:0]          rad_ff, rad_in, root_ff, root_in, bit_ff, bit_in;
   logic signed [PHASE_W-1:0]  phase_ff, phase_in;
   logic signed [ELEV_W-1:0]   elev_ff, elev_in;
   logic                       clip_ff, clip_in;

   // Output register.
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [7:0]                 rsp_rng_ff;
   logic [4:0]                 rsp_lag_ff;
   logic signed [PHASE_W-1:0]  rsp_phase_ff;
   logic signed [ELEV_W-1:0]   rsp_elev_ff;
   logic                       rsp_clip_ff;
   logic                       rsp_load;

   // Shared CORDIC.
   logic                       cor_start, cor_done;
   logic signed [CORR_W-1:0]   cor_x, cor_y;
   logic [ANGLE_W-1:0]         cor_angle;

   // Datapath temporaries.
   logic                       req_xfer, in_range;
   logic [ANGLE_W-1:0]         diff_mag;
   logic [PROD_W-1:0]          prod_rnd;
   logic [PHASE_W-1:0]         phase_mag;
   logic [58:0]                over_limit;
   logic [57:0]                den_shift;
   logic [2*QUOT_W-1:0]        quot_sq;
   logic [ROOT_W-1:0]          root_trial, root_nx;
   logic [ANGLE_W-1:0]         eb_mag;
   logic [37:0]                elev_prod;
   logic [15:0]                elev_mag;
   logic [ELEV_W-1:0]          elev_sat;

   iphe_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cor_start),
      .x_in  (cor_x),
      .y_in  (cor_y),
      .done  (cor_done),
      .angle (cor_angle)
   );

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign in_range  = (32'(req_range_index) < 32'(MAX_RANGES)) &&
                      (32'(req_lag_index) < 32'(MAX_LAGS));

   always_ff @(posedge clock) begin
      if (reset) begin
         freq_ff <= FREQ_RESET;
         base_ff <= BASE_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_FREQ: freq_ff <= csr_wdata;
            REG_BASE: base_ff <= csr_wdata[BASE_W-1:0];
            default:  ;
         endcase
      end
   end

   always_comb begin
      // Datapath helpers.
      diff_mag   = diff_ff[ANGLE_W-1] ? (~diff_ff + 1'b1) : diff_ff;
      prod_rnd   = prod_ff + (PROD_W'(1) << 46);
      phase_mag  = PHASE_W'(prod_rnd >> 47);
      over_limit = (59'(den_ff) << 30) + 59'(den_ff);
      den_shift  = 58'(den_ff) << k_ff;
      quot_sq    = 62'(quot_ff) * 62'(quot_ff);
      root_trial = root_ff + bit_ff;
      root_nx    = (rad_ff >= root_trial) ? ((root_ff >> 1) + bit_ff) : (root_ff >> 1);
      eb_mag     = cor_angle[ANGLE_W-1] ? (~cor_angle + 1'b1) : cor_angle;
      elev_prod  = 38'(eb_mag) * 38'(DEG_SCALE) + (38'(1) << 21);
      elev_mag   = 16'(elev_prod >> 22);
      elev_sat   = (elev_mag > 16'(ELEV_LIMIT)) ? ELEV_LIMIT : elev_mag[ELEV_W-1:0];

      state_in    = state_ff;
      rng_in      = rng_ff;
      lag_in      = lag_ff;
      phase_ok_in = phase_ok_ff;
      acf_re_in   = acf_re_ff;
      acf_im_in   = acf_im_ff;
      ang_x_in    = ang_x_ff;
      diff_in     = diff_ff;
      prod_in     = prod_ff;
      num_in      = num_ff;
      den_in      = den_ff;
      quot_in     = quot_ff;
      k_in        = k_ff;
      rad_in      = rad_ff;
      root_in     = root_ff;
      bit_in      = bit_ff;
      phase_in    = phase_ff;
      elev_in     = elev_ff;
      clip_in     = clip_ff;
      cor_start   = 1'b0;
      cor_x       = req_xcf_real;
      cor_y       = req_xcf_imag;
      rsp_load    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               rng_in      = req_range_index;
               lag_in      = req_lag_index;
               acf_re_in   = req_acf_real;
               acf_im_in   = req_acf_imag;
               phase_ok_in = req_lag_valid && in_range &&
                             !(req_acf_real == 0 && req_acf_imag == 0) &&
                             !(req_xcf_real == 0 && req_xcf_imag == 0);
               cor_start   = 1'b1;
               state_in    = ST_CORD_X;
            end
         end
         ST_CORD_X: begin
            if (cor_done) begin
               ang_x_in  = cor_angle;
               cor_x     = acf_re_ff;
               cor_y     = acf_im_ff;
               cor_start = 1'b1;
               state_in  = ST_CORD_A;
            end
         end
         ST_CORD_A: begin
            if (cor_done) begin
               diff_in  = ang_x_ff - cor_angle;
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            prod_in  = PROD_W'(diff_mag) * PROD_W'(PI_Q29);
            den_in   = DEN_W'(freq_ff * base_ff) << 2;
            num_in   = NUM_W'(diff_mag) * NUM_W'(LAMBDA_SCALE) +
                       NUM_W'((DEN_W'(freq_ff * base_ff) << 2) >> 1);
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            phase_in = !phase_ok_ff ? '0 :
                       diff_ff[ANGLE_W-1] ? -signed'(phase_mag) : signed'(phase_mag);
            quot_in  = '0;
            k_in     = CNT_W'(QUOT_W - 1);
            clip_in  = 1'b0;
            elev_in  = '0;
            if (diff_ff == '0) begin
               state_in = ST_FINISH;
            end else if (den_ff == '0 || 59'(num_ff) >= over_limit) begin
               clip_in  = 1'b1;
               elev_in  = diff_ff[ANGLE_W-1] ? -signed'(ELEV_LIMIT) : signed'(ELEV_LIMIT);
               state_in = ST_FINISH;
            end else begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (58'(num_ff) >= den_shift) begin
               num_in         = num_ff - NUM_W'(den_shift);
               quot_in[k_ff]  = 1'b1;
            end
            k_in = k_ff - 1'b1;
            if (k_ff == '0) begin
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            rad_in   = (ROOT_W'(1) << 60) - ROOT_W'(quot_sq);
            root_in  = '0;
            bit_in   = ROOT_W'(1) << 60;
            k_in     = CNT_W'(30);
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            if (rad_ff >= root_trial) begin
               rad_in = rad_ff - root_trial;
            end
            root_in = root_nx;
            bit_in  = bit_ff >> 2;
            k_in    = k_ff - 1'b1;
            if (k_ff == '0) begin
               cor_x     = CORR_W'(root_nx);
               cor_y     = diff_ff[ANGLE_W-1] ? -signed'(CORR_W'(quot_ff))
                                              : signed'(CORR_W'(quot_ff));
               cor_start = 1'b1;
               state_in  = ST_CORD_E;
            end
         end
         ST_CORD_E: begin
            if (cor_done) begin
               elev_in  = cor_angle[ANGLE_W-1] ? -signed'(elev_sat) : signed'(elev_sat);
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rng_ff      <= rng_in;
      lag_ff      <= lag_in;
      phase_ok_ff <= phase_ok_in;
      acf_re_ff   <= acf_re_in;
      acf_im_ff   <= acf_im_in;
      ang_x_ff    <= ang_x_in;
      diff_ff     <= diff_in;
      prod_ff     <= prod_in;
      num_ff      <= num_in;
      den_ff      <= den_in;
      quot_ff     <= quot_in;
      k_ff        <= k_in;
      rad_ff      <= rad_in;
      root_ff     <= root_in;
      bit_ff      <= bit_in;
      phase_ff    <= phase_in;
      elev_ff     <= elev_in;
      clip_ff     <= clip_in;
      if (rsp_load) begin
         rsp_rng_ff   <= rng_ff;
         rsp_lag_ff   <= lag_ff;
         rsp_phase_ff <= phase_ff;
         rsp_elev_ff  <= elev_ff;
         rsp_clip_ff  <= clip_ff;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_range_index_out   = rsp_rng_ff;
   assign rsp_lag_index_out     = rsp_lag_ff;
   assign rsp_phase_difference  = rsp_phase_ff;
   assign rsp_elevation_angle   = rsp_elev_ff;
   assign rsp_elevation_clipped = rsp_clip_ff;

   // A new result only appears as the sequencer leaves its final state.
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result raised outside the final state");

   // The CORDIC only reports back while the sequencer waits for it.
   a_cordic_done_expected: assert property (@(posedge clock) disable iff (reset)
      cor_done |-> (state_ff == ST_CORD_X || state_ff == ST_CORD_A ||
                    state_ff == ST_CORD_E))
      else $error("CORDIC finished while not awaited");

   // A clipped elevation sits at plus or minus 90 degrees.
   a_clip_is_full_scale: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_clip_ff) |->
         (rsp_elev_ff == signed'(ELEV_LIMIT) || rsp_elev_ff == -signed'(ELEV_LIMIT)))
      else $error("clipped elevation not at full scale");

endmodule
